FILE: hw/rtl/assert_macros.svh
// Assertion macros; the assertions compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FCFS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define FCFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FCFS_ASSERT_IMPL(lbl, ante, cons, msg)
`define FCFS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hw/rtl/fcfs_pkg.sv
package fcfs_pkg;

    localparam int TABLE_SLOTS = 1024;
    localparam int BLOCK_W     = 3;
    localparam int BLOCK_SLOTS = 1 << BLOCK_W;
    localparam int DIR_ENTRIES = 64;
    localparam int NAME_BITS   = 32;

    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(TABLE_SLOTS + BLOCK_SLOTS) + 1;
    localparam int DIR_W  = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;

    localparam logic [1:0] TAG_EMPTY    = 2'd0;
    localparam logic [1:0] TAG_RESERVED = 2'd1;
    localparam logic [1:0] TAG_END      = 2'd2;
    localparam logic [1:0] TAG_LINK     = 2'd3;

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_ERASE  = 2'd2;
    localparam logic [1:0] OP_DEEP   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_NO_SPACE  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] name_key;
        logic [7:0]  data_char;
    } cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [9:0] slot_index;
    } resp_t;

    typedef struct packed {
        logic [1:0]        tag;
        logic [SLOT_W-1:0] next;
    } chain_entry_t;

    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] addr;
        chain_entry_t      entry;
        logic              bwe;
        logic [7:0]        bdata;
    } chain_wr_t;

    typedef struct packed {
        logic                 set;
        logic                 clr;
        logic [DIR_W-1:0]     idx;
        logic [NAME_BITS-1:0] key;
        logic [SLOT_W-1:0]    head;
    } dir_wr_t;

    typedef struct packed {
        logic                 valid;
        logic [NAME_BITS-1:0] key;
        logic [SLOT_W-1:0]    head;
        logic                 free_found;
        logic [DIR_W-1:0]     free_idx;
    } dir_rd_t;

endpackage

FILE: hw/rtl/fcfs_chain_mem.sv
module fcfs_chain_mem
    import fcfs_pkg::*;
(
    input  logic              clk,
    input  logic [SLOT_W-1:0] raddr,
    output chain_entry_t      rdata,
    input  chain_wr_t         wr
);

    chain_entry_t chain_mem [TABLE_SLOTS];
    logic [7:0]   byte_mem  [TABLE_SLOTS];
    chain_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            chain_mem[wr.addr] <= wr.entry;
        end
        if (wr.bwe)
        begin
            byte_mem[wr.addr] <= wr.bdata;
        end
        // write-first on a same-entry collision
        if (wr.we && (wr.addr == raddr))
        begin
            rdata_reg <= wr.entry;
        end
        else
        begin
            rdata_reg <= chain_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/fcfs_dir.sv
module fcfs_dir
    import fcfs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIR_W-1:0] raddr,
    output dir_rd_t          rd,
    input  dir_wr_t          wr
);

    logic [NAME_BITS+SLOT_W-1:0] dir_mem [DIR_ENTRIES];
    logic [DIR_ENTRIES-1:0]      valid_reg;
    logic [NAME_BITS+SLOT_W-1:0] rdata_reg;
    logic                        rvalid_reg;
    logic                        free_found;
    logic [DIR_W-1:0]            free_idx;

    always_ff @(posedge clk)
    begin
        if (wr.set)
        begin
            dir_mem[wr.idx] <= {wr.key, wr.head};
        end
        rdata_reg <= dir_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            if (wr.set)
            begin
                valid_reg[wr.idx] <= 1'b1;
            end
            if (wr.clr)
            begin
                valid_reg[wr.idx] <= 1'b0;
            end
            rvalid_reg <= valid_reg[raddr];
        end
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = DIR_ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = DIR_W'(i);
            end
        end
    end

    assign rd.valid      = rvalid_reg;
    assign rd.key        = rdata_reg[NAME_BITS+SLOT_W-1:SLOT_W];
    assign rd.head       = rdata_reg[SLOT_W-1:0];
    assign rd.free_found = free_found;
    assign rd.free_idx   = free_idx;

endmodule

FILE: hw/rtl/fcfs_ctrl.sv
`include "assert_macros.svh"

module fcfs_ctrl
    import fcfs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  cmd_t              cmd,
    output logic              busy,
    input  logic              out_free,
    output logic              res_valid,
    output resp_t             res,
    output logic [SLOT_W-1:0] chain_raddr,
    input  chain_entry_t      chain_rd,
    output chain_wr_t         chain_wr,
    output logic [DIR_W-1:0]  dir_raddr,
    input  dir_rd_t           dir_rd,
    output dir_wr_t           dir_wr
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DSCAN = 4'd2;
    localparam logic [3:0] S_HEAD  = 4'd3;
    localparam logic [3:0] S_WALK  = 4'd4;
    localparam logic [3:0] S_NEAR  = 4'd5;
    localparam logic [3:0] S_BLK   = 4'd6;
    localparam logic [3:0] S_WTAIL = 4'd7;
    localparam logic [3:0] S_FREE  = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam logic [CNT_W-1:0] T_CNT = CNT_W'(TABLE_SLOTS);
    localparam logic [CNT_W-1:0] B_CNT = CNT_W'(BLOCK_SLOTS);
    localparam logic [SLOT_W-1:0] B_MASK = ~SLOT_W'(BLOCK_SLOTS - 1);

    logic [3:0]           state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [NAME_BITS-1:0] key_reg, key_next;
    logic [7:0]           ch_reg, ch_next;
    logic [CNT_W-1:0]     caddr_reg, caddr_next;
    logic [DIR_W-1:0]     daddr_reg, daddr_next;
    logic [CNT_W-1:0]     steps_reg, steps_next;
    logic [SLOT_W-1:0]    tail_reg, tail_next;
    logic [CNT_W-1:0]     nend_reg, nend_next;
    logic [1:0]           status_reg, status_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;

    logic [SLOT_W-1:0] cur;
    logic [SLOT_W-1:0] head_cl;
    logic              link_ok;
    logic [CNT_W-1:0]  inc1;
    logic [CNT_W-1:0]  incb;
    logic [SLOT_W-1:0] bstart;

    assign cur     = caddr_reg[SLOT_W-1:0];
    assign head_cl = (CNT_W'(dir_rd.head) >= T_CNT) ? '0 : dir_rd.head;
    assign link_ok = (steps_reg < T_CNT) && (chain_rd.tag == TAG_LINK)
                     && (CNT_W'(chain_rd.next) < T_CNT);
    assign inc1    = caddr_reg + CNT_W'(1);
    assign incb    = caddr_reg + B_CNT;
    assign bstart  = cur & B_MASK;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        key_next    = key_reg;
        ch_next     = ch_reg;
        caddr_next  = caddr_reg;
        daddr_next  = daddr_reg;
        steps_next  = steps_reg;
        tail_next   = tail_reg;
        nend_next   = nend_reg;
        status_next = status_reg;
        slot_next   = slot_reg;
        chain_wr    = '0;
        dir_wr      = '0;
        res_valid   = 1'b0;

        case (state_reg)
            S_CLR:
            begin
                chain_wr.we    = 1'b1;
                chain_wr.addr  = cur;
                chain_wr.entry = '{tag: TAG_EMPTY, next: '0};
                chain_wr.bwe   = 1'b1;
                chain_wr.bdata = 8'd0;
                if (inc1 == T_CNT)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    caddr_next = inc1;
                end
            end
            S_IDLE:
            begin
                status_next = ST_OK;
                slot_next   = '0;
                if (cmd_valid)
                begin
                    op_next  = cmd.operation;
                    key_next = NAME_BITS'(cmd.name_key);
                    ch_next  = cmd.data_char;
                    if (cmd.operation == OP_CREATE)
                    begin
                        if (dir_rd.free_found)
                        begin
                            caddr_next = '0;
                            state_next = S_BLK;
                        end
                        else
                        begin
                            status_next = ST_NO_SPACE;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        daddr_next = '0;
                        state_next = S_DSCAN;
                    end
                end
            end
            S_DSCAN:
            begin
                if (dir_rd.valid && (dir_rd.key == key_reg))
                begin
                    caddr_next = CNT_W'(head_cl);
                    steps_next = '0;
                    if (op_reg == OP_APPEND)
                    begin
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        dir_wr.clr = 1'b1;
                        dir_wr.idx = daddr_reg;
                        state_next = S_FREE;
                    end
                end
                else if (daddr_reg == DIR_W'(DIR_ENTRIES - 1))
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    daddr_next = daddr_reg + DIR_W'(1);
                end
            end
            S_HEAD:
            begin
                if (chain_rd.tag == TAG_RESERVED)
                begin
                    chain_wr.we    = 1'b1;
                    chain_wr.addr  = cur;
                    chain_wr.entry = '{tag: TAG_END, next: chain_rd.next};
                    chain_wr.bwe   = 1'b1;
                    chain_wr.bdata = ch_reg;
                    slot_next      = cur;
                    state_next     = S_DONE;
                end
                else
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                if (link_ok)
                begin
                    caddr_next = CNT_W'(chain_rd.next);
                    steps_next = steps_reg + CNT_W'(1);
                end
                else
                begin
                    tail_next  = cur;
                    caddr_next = CNT_W'(bstart);
                    nend_next  = CNT_W'(bstart) + B_CNT;
                    state_next = S_NEAR;
                end
            end
            S_NEAR:
            begin
                if (chain_rd.tag == TAG_EMPTY)
                begin
                    chain_wr.we    = 1'b1;
                    chain_wr.addr  = cur;
                    chain_wr.entry = '{tag: TAG_END, next: '0};
                    chain_wr.bwe   = 1'b1;
                    chain_wr.bdata = ch_reg;
                    slot_next      = cur;
                    state_next     = S_WTAIL;
                end
                else if ((inc1 == nend_reg) || (inc1 >= T_CNT))
                begin
                    caddr_next = '0;
                    state_next = S_BLK;
                end
                else
                begin
                    caddr_next = inc1;
                end
            end
            S_BLK:
            begin
                if (chain_rd.tag == TAG_EMPTY)
                begin
                    chain_wr.we   = 1'b1;
                    chain_wr.addr = cur;
                    slot_next     = cur;
                    if (op_reg == OP_CREATE)
                    begin
                        chain_wr.entry = '{tag: TAG_RESERVED, next: '0};
                        dir_wr.set     = 1'b1;
                        dir_wr.idx     = dir_rd.free_idx;
                        dir_wr.key     = key_reg;
                        dir_wr.head    = cur;
                        state_next     = S_DONE;
                    end
                    else
                    begin
                        chain_wr.entry = '{tag: TAG_END, next: '0};
                        chain_wr.bwe   = 1'b1;
                        chain_wr.bdata = ch_reg;
                        state_next     = S_WTAIL;
                    end
                end
                else if (incb >= T_CNT)
                begin
                    status_next = ST_NO_SPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    caddr_next = incb;
                end
            end
            S_WTAIL:
            begin
                chain_wr.we    = 1'b1;
                chain_wr.addr  = tail_reg;
                chain_wr.entry = '{tag: TAG_LINK, next: slot_reg};
                state_next     = S_DONE;
            end
            S_FREE:
            begin
                chain_wr.we    = 1'b1;
                chain_wr.addr  = cur;
                chain_wr.entry = '{tag: TAG_EMPTY, next: '0};
                chain_wr.bwe   = (op_reg == OP_DEEP);
                chain_wr.bdata = 8'd0;
                if (link_ok)
                begin
                    caddr_next = CNT_W'(chain_rd.next);
                    steps_next = steps_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            caddr_reg <= '0;
            daddr_reg <= '0;
            steps_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            caddr_reg <= caddr_next;
            daddr_reg <= daddr_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        ch_reg     <= ch_next;
        tail_reg   <= tail_next;
        nend_reg   <= nend_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
    end

    assign busy           = (state_reg != S_IDLE);
    assign chain_raddr    = caddr_next[SLOT_W-1:0];
    assign dir_raddr      = daddr_next;
    assign res.status     = status_reg;
    assign res.slot_index = (status_reg == ST_OK) ? 10'(slot_reg) : 10'd0;

    `FCFS_ASSERT_IMPL(a_wtail_src, state_reg == S_WTAIL,
        $past(state_reg) == S_NEAR || $past(state_reg) == S_BLK, "tail link out of order")
    `FCFS_ASSERT_IMPL(a_steps_bound, 1'b1, steps_reg <= T_CNT, "walk step bound exceeded")
    `FCFS_ASSERT_NEXT(a_done_idle, res_valid, state_reg == S_IDLE, "no return to idle")
    `FCFS_ASSERT_IMPL(a_dir_set_create, dir_wr.set, op_reg == OP_CREATE,
        "directory entry taken outside create")

endmodule

FILE: hw/rtl/fat_chain_file_store.sv
// FAT-style byte store: a chain table, a byte store and a name directory.
// cmd channel (cmd_valid / cmd_stall / cmd): one word per command, accepted
// when cmd_valid is high and cmd_stall low. Operations: create, append one
// character, erase, deep erase.
// resp channel (resp_valid / resp_stall / resp): one word per command,
// status and slot index, held stable while resp_stall is high.
// Create scans the block starts for a free one; append, erase and deep erase
// scan the directory one entry a cycle (up to DIR_ENTRIES), then walk the
// chain one slot a cycle; append adds a scan of up to BLOCK_SLOTS slots in
// the tail's block and of up to TABLE_SLOTS / BLOCK_SLOTS block starts. All walks go
// through the single read port of the chain memory.
// One command at a time: cmd_stall stays high until the result is passed to
// the output register; the next command may be taken while that word waits.
// After reset the chain and byte memories are cleared one entry a cycle (all
// TABLE_SLOTS = 1024 entries) with cmd_stall high.
module fat_chain_file_store
    import fcfs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    output logic  cmd_stall,
    input  cmd_t  cmd,
    output logic  resp_valid,
    input  logic  resp_stall,
    output resp_t resp
);

    logic              busy;
    logic              out_free;
    logic              res_valid;
    resp_t             res;
    logic [SLOT_W-1:0] chain_raddr;
    chain_entry_t      chain_rd;
    chain_wr_t         chain_wr;
    logic [DIR_W-1:0]  dir_raddr;
    dir_rd_t           dir_rd;
    dir_wr_t           dir_wr;
    logic              out_valid_reg;
    resp_t             out_data_reg;

    assign out_free = !out_valid_reg || !resp_stall;

    fcfs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .busy        (busy),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res         (res),
        .chain_raddr (chain_raddr),
        .chain_rd    (chain_rd),
        .chain_wr    (chain_wr),
        .dir_raddr   (dir_raddr),
        .dir_rd      (dir_rd),
        .dir_wr      (dir_wr)
    );

    fcfs_chain_mem u_chain (
        .clk   (clk),
        .raddr (chain_raddr),
        .rdata (chain_rd),
        .wr    (chain_wr)
    );

    fcfs_dir u_dir (
        .clk   (clk),
        .rst_n (rst_n),
        .raddr (dir_raddr),
        .rd    (dir_rd),
        .wr    (dir_wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!resp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign cmd_stall  = busy;
    assign resp_valid = out_valid_reg;
    assign resp       = out_data_reg;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import fcfs_pkg::*;

    localparam int  CYCLE_LIMIT = 30000000;
    localparam int  SETTLE      = 3000;

    logic  clk;
    logic  rst_n;
    logic  cmd_valid;
    logic  cmd_stall;
    cmd_t  cmd;
    logic  resp_valid;
    logic  resp_stall;
    resp_t resp;

    fat_chain_file_store DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .resp_valid (resp_valid),
        .resp_stall (resp_stall),
        .resp       (resp)
    );

    // predicted store state
    logic [1:0]           tag_q  [TABLE_SLOTS];
    logic [SLOT_W-1:0]    next_q [TABLE_SLOTS];
    logic                 dir_valid [DIR_ENTRIES];
    logic [NAME_BITS-1:0] dir_key   [DIR_ENTRIES];
    logic [SLOT_W-1:0]    dir_head  [DIR_ENTRIES];

    resp_t pending_resp[$];
    int    send_gap_pct;
    int    stall_pct;
    int    mismatches;
    int    words_sent;
    int    words_checked;
    int    cycles;
    int    n_ok, n_not_found, n_no_space;
    logic [31:0] key_pool[12];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles, %0d words outstanding", cycles,
                         pending_resp.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    function automatic int first_free_block_start();
        for (int i = 0; i < TABLE_SLOTS; i += BLOCK_SLOTS)
            if (tag_q[i] == TAG_EMPTY)
                return i;
        return -1;
    endfunction

    function automatic resp_t model_command(cmd_t c);
        resp_t r;
        int blk, d, pos, steps, ns, start, nxt;
        r.status     = ST_OK;
        r.slot_index = '0;
        d = -1;
        if (c.operation == OP_CREATE)
        begin
            blk = first_free_block_start();
            for (int i = DIR_ENTRIES - 1; i >= 0; i--)
                if (!dir_valid[i])
                    d = i;
            if (blk < 0 || d < 0)
                r.status = ST_NO_SPACE;
            else
            begin
                dir_valid[d]  = 1'b1;
                dir_key[d]    = c.name_key[NAME_BITS-1:0];
                dir_head[d]   = blk[SLOT_W-1:0];
                tag_q[blk]    = TAG_RESERVED;
                next_q[blk]   = '0;
                r.slot_index  = blk[9:0];
            end
            return r;
        end
        for (int i = DIR_ENTRIES - 1; i >= 0; i--)
            if (dir_valid[i] && dir_key[i] == c.name_key[NAME_BITS-1:0])
                d = i;
        if (d < 0)
        begin
            r.status = ST_NOT_FOUND;
            return r;
        end
        pos = int'(dir_head[d]);
        if (c.operation == OP_APPEND)
        begin
            if (tag_q[pos] == TAG_RESERVED)
            begin
                tag_q[pos]   = TAG_END;
                r.slot_index = pos[9:0];
                return r;
            end
            steps = 0;
            while (steps < TABLE_SLOTS && tag_q[pos] == TAG_LINK)
            begin
                pos = int'(next_q[pos]);
                steps++;
            end
            ns    = -1;
            start = (pos / BLOCK_SLOTS) * BLOCK_SLOTS;
            for (int i = start + BLOCK_SLOTS - 1; i >= start; i--)
                if (i < TABLE_SLOTS && tag_q[i] == TAG_EMPTY)
                    ns = i;
            if (ns < 0)
                ns = first_free_block_start();
            if (ns < 0)
                r.status = ST_NO_SPACE;
            else
            begin
                tag_q[ns]    = TAG_END;
                next_q[ns]   = '0;
                tag_q[pos]   = TAG_LINK;
                next_q[pos]  = ns[SLOT_W-1:0];
                r.slot_index = ns[9:0];
            end
            return r;
        end
        // erase and deep erase look the same from outside
        dir_valid[d] = 1'b0;
        dir_key[d]   = '0;
        dir_head[d]  = '0;
        steps = 0;
        while (steps < TABLE_SLOTS && tag_q[pos] == TAG_LINK)
        begin
            nxt         = int'(next_q[pos]);
            tag_q[pos]  = TAG_EMPTY;
            next_q[pos] = '0;
            pos         = nxt;
            steps++;
        end
        tag_q[pos]  = TAG_EMPTY;
        next_q[pos] = '0;
        return r;
    endfunction

    task automatic send_word(input logic [1:0] op, input logic [31:0] key,
                             input logic [7:0] ch);
        cmd_t w;
        w.operation = op;
        w.name_key  = key;
        w.data_char = ch;
        cmd_valid <= 1'b1;
        cmd       <= w;
        do
            @(posedge clk);
        while (cmd_stall);
        pending_resp.push_back(model_command(w));
        words_sent++;
        if ($urandom_range(99) < send_gap_pct)
        begin
            cmd_valid <= 1'b0;
            cmd       <= cmd_t'({$urandom, $urandom});
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        resp_t want;
        if (rst_n && resp_valid && !resp_stall)
        begin
            words_checked++;
            if (pending_resp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word status=%0d slot=%0d", resp.status,
                             resp.slot_index);
            end
            else
            begin
                want = pending_resp.pop_front();
                case (want.status)
                    ST_OK:        n_ok++;
                    ST_NOT_FOUND: n_not_found++;
                    default:      n_no_space++;
                endcase
                if (resp.status !== want.status || resp.slot_index !== want.slot_index)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch at %0t: status exp %0d got %0d, slot exp %0d got %0d",
                                 $realtime, want.status, resp.status,
                                 want.slot_index, resp.slot_index);
                end
            end
        end
        resp_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic drain();
        cmd_valid <= 1'b0;
        while (pending_resp.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_basic_chain();
        send_word(OP_APPEND, key_pool[0], 8'h41);
        send_word(OP_ERASE, key_pool[0], 8'h00);
        send_word(OP_DEEP, key_pool[0], 8'hFF);
        send_word(OP_CREATE, key_pool[0], 8'h00);
        send_word(OP_APPEND, key_pool[0], 8'h00);
        for (int i = 0; i < 9; i++)
            send_word(OP_APPEND, key_pool[0], 8'(255 - i));
        send_word(OP_CREATE, key_pool[1], 8'h00);
        send_word(OP_CREATE, key_pool[0], 8'h55);
        send_word(OP_APPEND, key_pool[0], 8'hAA);
        send_word(OP_APPEND, key_pool[1], 8'h12);
        send_word(OP_ERASE, key_pool[0], 8'h00);
        send_word(OP_APPEND, key_pool[0], 8'h34);
        send_word(OP_DEEP, key_pool[0], 8'h00);
        send_word(OP_CREATE, 32'hFFFF_FFFF, 8'h00);
        send_word(OP_APPEND, 32'hFFFF_FFFF, 8'h80);
        send_word(OP_DEEP, 32'hFFFF_FFFF, 8'h00);
        send_word(OP_ERASE, key_pool[1], 8'h00);
        drain();
    endtask

    task automatic test_directory_full();
        for (int i = 0; i <= DIR_ENTRIES; i++)
            send_word(OP_CREATE, 32'h1000 + i, 8'h00);
        for (int i = 0; i < DIR_ENTRIES; i++)
            send_word((i % 2) ? OP_DEEP : OP_ERASE, 32'h1000 + i, 8'h00);
        drain();
    endtask

    task automatic test_table_full();
        send_word(OP_CREATE, key_pool[2], 8'h00);
        for (int i = 0; i <= TABLE_SLOTS; i++)
            send_word(OP_APPEND, key_pool[2], 8'($urandom));
        send_word(OP_CREATE, key_pool[3], 8'h00);
        send_word(OP_DEEP, key_pool[2], 8'h00);
        drain();
    endtask

    task automatic test_random_mix(input int count);
        logic [1:0]  op;
        logic [31:0] key;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            op   = (pick < 22) ? OP_CREATE : (pick < 78) ? OP_APPEND :
                   (pick < 89) ? OP_ERASE : OP_DEEP;
            key  = ($urandom_range(19) == 0) ? $urandom : key_pool[$urandom_range(11)];
            send_word(op, key, 8'($urandom));
        end
        drain();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        resp_stall    = 1'b0;
        send_gap_pct  = 0;
        stall_pct     = 0;
        mismatches    = 0;
        words_sent    = 0;
        words_checked = 0;
        n_ok = 0;
        n_not_found = 0;
        n_no_space = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
        begin
            tag_q[i]  = TAG_EMPTY;
            next_q[i] = '0;
        end
        for (int i = 0; i < DIR_ENTRIES; i++)
        begin
            dir_valid[i] = 1'b0;
            dir_key[i]   = '0;
            dir_head[i]  = '0;
        end
        for (int i = 0; i < 12; i++)
            key_pool[i] = (i == 11) ? 32'h0 : $urandom;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_chain();
        send_gap_pct = 48;
        test_directory_full();
        send_gap_pct = 0;
        test_table_full();
        send_gap_pct = 0;  stall_pct = 0;  test_random_mix(150);
        send_gap_pct = 48; stall_pct = 0;  test_random_mix(150);
        send_gap_pct = 0;  stall_pct = 48; test_random_mix(150);
        send_gap_pct = 7;  stall_pct = 7;  test_random_mix(150);
        drain();
        stall_pct = 0;
        repeat (SETTLE) @(posedge clk);

        $display("%0d commands sent, %0d words checked: %0d ok, %0d not found, %0d no space",
                 words_sent, words_checked, n_ok, n_not_found, n_no_space);
        $display("covered chain growth, full directory, full table and four idling mixes");
        if (mismatches == 0 && pending_resp.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
